// ----- hw/rtl/hms_pkg.sv -----
`timescale 1ns / 1ps

package hms_pkg;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [5:0] SecTop  = 6'd59;
  localparam logic [5:0] MinTop  = 6'd59;
  localparam logic [4:0] HourTop = 5'd23;
  localparam logic [7:0] SatMax  = 8'hff;

  localparam logic [7:0] TicksPerSecondRst = 8'd3;
  localparam logic [7:0] ExitSecondsRst    = 8'd20;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MODE = 2'd1,
    CMD_UP   = 2'd2,
    CMD_DOWN = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_RUN     = 2'd0,
    MODE_HOURS   = 2'd1,
    MODE_MINUTES = 2'd2,
    MODE_SECONDS = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_TICKS_PER_SECOND = 1'b0,
    CFG_EXIT_SECONDS     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } bcd_pair_t;

  function automatic logic [5:0] step_up(input logic [5:0] v, input logic [5:0] top);
    logic [5:0] r;
    r = (v >= top) ? 6'd0 : v + 6'd1;
    return r;
  endfunction

  function automatic logic [5:0] step_down(input logic [5:0] v, input logic [5:0] top);
    logic [5:0] r;
    r = (v == 6'd0 || v > top) ? top : v - 6'd1;
    return r;
  endfunction

  // split 0..63 into tens and ones: multiply by reciprocal 205/2048
  function automatic bcd_pair_t to_bcd(input logic [5:0] v);
    logic [13:0] prod;
    logic [2:0]  q;
    logic [5:0]  rem;
    bcd_pair_t   r;
    prod   = {8'd0, v} * 14'd205;
    q      = prod[13:11];
    rem    = v - ({3'd0, q} * 6'd10);
    r.tens = q;
    r.ones = rem[3:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/hms_clock_with_set_mode_unit.sv -----
`timescale 1ns / 1ps
// 24-hour clock with time-setting mode.
// Input channel (in_*): one item per timer tick or key event; in_tdata carries
//   cmd (tick, mode, up, down) and keys_idle. Ticks are divided down to
//   seconds by ticks_per_second; mode cycles 0..3 and up/down step the
//   selected field with wrap. Idle seconds return mode to 0 at exit_seconds.
// Output channel (out_*): one item per input item, the six BCD time digits,
//   the mode and the blink flag, taken after the input item is applied.
// Configuration channel (cfg_*): index 0 ticks_per_second, 1 exit_seconds;
//   always ready, write only while the block is idle.
// out_tvalid rises in the cycle after input accept. Throughput: one item per
//   cycle while out_tready is high; the state update and digit split sit between
//   the clock state registers and the output register.
// Reset: time, mode, tick and idle counters clear, registers take 3 and 20,
//   out_tvalid drops.
// Stall: while out_tvalid is high and out_tready low, the result holds and
//   in_tready is low; with out_tready high a new item enters every cycle.
module hms_clock_with_set_mode_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [hms_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [1:0] cmd, [2] keys_idle, [7:3] zero
  input  logic [hms_pkg::InDataW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [3:0] sec_ones, [6:4] sec_tens, [10:7] min_ones, [13:11] min_tens,
  // [17:14] hour_ones, [19:18] hour_tens, [21:20] set_mode,
  // [22] blank_selected, [23] zero
  output logic [hms_pkg::OutDataW-1:0]  out_tdata
);
  import hms_pkg::*;

  logic [7:0]  tps_r, exit_r;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  mode_t       mode_r, mode_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [7:0]  idle_r, idle_nxt;
  logic        out_valid_r;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;

  cmd_t        cmd;
  logic        keys_idle;
  logic        in_acc;
  logic [7:0]  sub_inc, idle_inc;
  logic [5:0]  hour_up6, hour_dn6, hour_wrap6;
  logic        blank;
  bcd_pair_t   sec_bcd, min_bcd, hour_bcd;

  assign cmd       = cmd_t'(in_tdata[1:0]);
  assign keys_idle = in_tdata[2];
  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign sub_inc    = (sub_r == SatMax) ? sub_r : sub_r + 8'd1;
  assign idle_inc   = (idle_r == SatMax) ? idle_r : idle_r + 8'd1;
  assign hour_up6   = step_up({1'b0, hour_r}, {1'b0, HourTop});
  assign hour_dn6   = step_down({1'b0, hour_r}, {1'b0, HourTop});
  assign hour_wrap6 = hour_up6;

  always_comb begin
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    mode_nxt = mode_r;
    sub_nxt  = sub_r;
    idle_nxt = idle_r;
    unique case (cmd)
      CMD_TICK: begin
        if (sub_inc >= tps_r) begin
          sub_nxt  = 8'd0;
          idle_nxt = idle_inc;
          if (idle_inc >= exit_r) begin
            mode_nxt = MODE_RUN;
          end
          if (sec_r >= SecTop) begin
            sec_nxt = 6'd0;
            if (min_r >= MinTop) begin
              min_nxt  = 6'd0;
              hour_nxt = hour_wrap6[4:0];
            end else begin
              min_nxt = min_r + 6'd1;
            end
          end else begin
            sec_nxt = sec_r + 6'd1;
          end
        end else begin
          sub_nxt = sub_inc;
        end
      end
      CMD_MODE: begin
        mode_nxt = mode_t'(mode_r + 2'd1);
        idle_nxt = 8'd0;
      end
      CMD_UP: begin
        idle_nxt = 8'd0;
        unique case (mode_r)
          MODE_HOURS:   hour_nxt = hour_up6[4:0];
          MODE_MINUTES: min_nxt  = step_up(min_r, MinTop);
          MODE_SECONDS: sec_nxt  = step_up(sec_r, SecTop);
          default: ;
        endcase
      end
      CMD_DOWN: begin
        idle_nxt = 8'd0;
        unique case (mode_r)
          MODE_HOURS:   hour_nxt = hour_dn6[4:0];
          MODE_MINUTES: min_nxt  = step_down(min_r, MinTop);
          MODE_SECONDS: sec_nxt  = step_down(sec_r, SecTop);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    sec_bcd  = to_bcd(sec_nxt);
    min_bcd  = to_bcd(min_nxt);
    hour_bcd = to_bcd({1'b0, hour_nxt});
    blank    = (mode_nxt != MODE_RUN) && (sub_nxt == 8'd0) && keys_idle;
    out_data_nxt = {1'b0, blank, mode_nxt,
                    hour_bcd.tens[1:0], hour_bcd.ones,
                    min_bcd.tens, min_bcd.ones,
                    sec_bcd.tens, sec_bcd.ones};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r  <= TicksPerSecondRst;
      exit_r <= ExitSecondsRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TICKS_PER_SECOND: tps_r  <= cfg_data;
        CFG_EXIT_SECONDS:     exit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= 6'd0;
      min_r  <= 6'd0;
      hour_r <= 5'd0;
      mode_r <= MODE_RUN;
      sub_r  <= 8'd0;
      idle_r <= 8'd0;
    end else if (in_acc) begin
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      mode_r <= mode_nxt;
      sub_r  <= sub_nxt;
      idle_r <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/hms_checker.sv -----
`timescale 1ns / 1ps
module hms_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [hms_pkg::OutDataW-1:0]  out_tdata
);
  import hms_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input blocked with free output slot");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item gave no result");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd9 && out_tdata[6:4] <= 3'd5
      && out_tdata[10:7] <= 4'd9 && out_tdata[13:11] <= 3'd5
      && out_tdata[17:14] <= 4'd9 && out_tdata[19:18] <= 2'd2
      && !(out_tdata[19:18] == 2'd2 && out_tdata[17:14] > 4'd3))
    else $error("time digits out of range");

endmodule

bind hms_clock_with_set_mode_unit hms_checker u_hms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
